>>> src/lsrc_pkg.sv
`default_nettype none
package lsrc_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;

	localparam int PIX_W  = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 10;
	localparam int SUM_W  = 20;
	localparam int CNT_W  = 11;
	localparam int STEP_W = $clog2(SUM_W);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd50;

	// one finished row that passed the threshold, waiting for its division
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
		logic [PIX_W-1:0] peak;
	} row_rec_t;

endpackage
`default_nettype wire

>>> src/lsrc_front.sv
`default_nettype none
module lsrc_front
	import lsrc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic             stall,
	input  wire logic [PIX_W-1:0] pixel_value,
	input  wire logic             row_end,
	input  wire logic             frame_end,
	input  wire logic             cfg_we,
	input  wire logic [PIX_W-1:0] cfg_wdata,
	output logic                  rec_push,
	output row_rec_t              rec
);

	logic [PIX_W-1:0] threshold_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] peak_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	logic [PIX_W-1:0] peak_n;
	logic [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0] cnt_n;
	logic             accept;
	logic             row_last;

	assign accept = push & ~stall;
	assign row_last = row_end | frame_end | (col_q == COL_W'(MAX_COLUMNS - 1));

	// first pixel of a row or a brighter one restarts the peak group
	always_comb begin
		peak_n = peak_q;
		sum_n = sum_q;
		cnt_n = cnt_q;
		if ((col_q == '0) || (pixel_value > peak_q)) begin
			peak_n = pixel_value;
			sum_n = SUM_W'(col_q);
			cnt_n = CNT_W'(1);
		end else if (pixel_value == peak_q) begin
			sum_n = sum_q + SUM_W'(col_q);
			cnt_n = cnt_q + CNT_W'(1);
		end
	end

	assign rec_push = accept & row_last & (peak_n > threshold_q);
	assign rec.row = row_q;
	assign rec.sum = sum_n;
	assign rec.cnt = cnt_n;
	assign rec.peak = peak_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			peak_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (row_last) begin
				col_q <= '0;
				peak_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
				if (frame_end || (row_q == ROW_W'(MAX_ROWS - 1))) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				peak_q <= peak_n;
				sum_q <= sum_n;
				cnt_q <= cnt_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/lsrc_queue.sv
`default_nettype none
module lsrc_queue
	import lsrc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_en,
	input  wire row_rec_t wr_rec,
	output logic          full,
	input  wire logic     rd_en,
	output logic          empty,
	output row_rec_t      rd_rec
);

	row_rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> src/lsrc_back.sv
`default_nettype none
module lsrc_back
	import lsrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rec_empty,
	input  wire row_rec_t          rec,
	output logic                   rec_pop,
	output logic                   empty,
	input  wire logic              pop,
	output logic [ROW_W-1:0]       row_index,
	output logic [COL_W-1:0]       centroid_column,
	output logic [PIX_W-1:0]       peak_level,
	output logic [CNT_W-1:0]       peak_pixels
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [ROW_W-1:0]  row_q;
	logic [PIX_W-1:0]  peak_q;
	logic              out_valid_q;

	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;
	logic              rem_ge;
	logic              out_load;
	logic              out_pop;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	assign rec_pop = (state_q == S_IDLE) & ~rec_empty;
	assign out_pop = pop & out_valid_q;
	assign out_load = (state_q == S_DONE) & (~out_valid_q | pop);
	assign empty = ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!rec_empty) begin
						state_q <= S_DIV;
						step_q <= STEP_W'(SUM_W - 1);
					end
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			quo_q <= rec.sum;
			rem_q <= '0;
			den_q <= rec.cnt;
			row_q <= rec.row;
			peak_q <= rec.peak;
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			row_index <= row_q;
			centroid_column <= quo_q[COL_W-1:0];
			peak_level <= peak_q;
			peak_pixels <= den_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> src/laser_stripe_row_centroid.sv
`default_nettype none
// Laser stripe row centroid: takes one pixel per clock (push/full) and, at the end of each
// row whose peak is above the threshold, delivers row index, truncated mean column of the
// peak pixels, peak level and peak pixel count through a queue-style result port
// (empty/pop). The pixel side accepts one pixel every cycle while full is low; each
// qualifying row takes a pop, the bit-per-cycle divider and a result load (held while
// an untaken result waits) in the back end; a two-row queue absorbs rows meanwhile, then
// full rises until the back end catches up. The user must write the threshold (reset
// 50) with cfg_we/cfg_wdata while no row is in progress; the block does not enforce it.
module laser_stripe_row_centroid
	import lsrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [PIX_W-1:0]  pixel_value,
	input  wire logic              row_end,
	input  wire logic              frame_end,
	input  wire logic              cfg_we,
	input  wire logic [PIX_W-1:0]  cfg_wdata,
	output logic                   empty,
	input  wire logic              pop,
	output logic [ROW_W-1:0]       row_index,
	output logic [COL_W-1:0]       centroid_column,
	output logic [PIX_W-1:0]       peak_level,
	output logic [CNT_W-1:0]       peak_pixels
);

	row_rec_t fr_rec;
	row_rec_t bk_rec;
	logic     fr_push;
	logic     q_full;
	logic     q_empty;
	logic     bk_pop;

	assign full = q_full;

	lsrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.stall       (q_full),
		.pixel_value (pixel_value),
		.row_end     (row_end),
		.frame_end   (frame_end),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rec_push    (fr_push),
		.rec         (fr_rec)
	);

	lsrc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_push),
		.wr_rec (fr_rec),
		.full   (q_full),
		.rd_en  (bk_pop),
		.empty  (q_empty),
		.rd_rec (bk_rec)
	);

	lsrc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec_empty       (q_empty),
		.rec             (bk_rec),
		.rec_pop         (bk_pop),
		.empty           (empty),
		.pop             (pop),
		.row_index       (row_index),
		.centroid_column (centroid_column),
		.peak_level      (peak_level),
		.peak_pixels     (peak_pixels)
	);

endmodule
`default_nettype wire

>>> src/lsrc_checker.sv
`default_nettype none
module lsrc_checker
	import lsrc_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             full,
	input wire logic             empty,
	input wire logic             pop,
	input wire logic [ROW_W-1:0] row_index,
	input wire logic [COL_W-1:0] centroid_column,
	input wire logic [PIX_W-1:0] peak_level,
	input wire logic [CNT_W-1:0] peak_pixels
);

	// a waiting result transaction holds its payload until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(row_index) && $stable(centroid_column)
			&& $stable(peak_level) && $stable(peak_pixels)))
		else $error("result changed before pop");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((peak_pixels != '0) && (peak_pixels <= CNT_W'(MAX_COLUMNS))))
		else $error("peak pixel count out of range");

	// reset leaves both sides idle
	a_reset: assert property (@(posedge clk)
		$past(!arst_n) |-> (empty && !full))
		else $error("not idle after reset");

endmodule

bind laser_stripe_row_centroid lsrc_checker u_lsrc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.full            (full),
	.empty           (empty),
	.pop             (pop),
	.row_index       (row_index),
	.centroid_column (centroid_column),
	.peak_level      (peak_level),
	.peak_pixels     (peak_pixels)
);
`default_nettype wire

>>> tb/sv/laser_stripe_row_centroid_test.sv
`timescale 1ns / 100ps
module laser_stripe_row_centroid_test;
	import lsrc_pkg::*;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int REPORT_LIMIT    = 100;

	typedef struct {
		bit [ROW_W-1:0] row;
		bit [COL_W-1:0] centroid;
		bit [PIX_W-1:0] peak;
		bit [CNT_W-1:0] count;
	} stripe_point_t;

	typedef enum int unsigned {
		SHAPE_NOISE,
		SHAPE_STRIPE,
		SHAPE_FLAT,
		SHAPE_GAPPED
	} row_shape_t;

	class centroid_scoreboard;
		bit [PIX_W-1:0] threshold;
		bit [COL_W-1:0] column;
		bit [ROW_W-1:0] row;
		bit [PIX_W-1:0] peak;
		bit [SUM_W-1:0] col_sum;
		bit [CNT_W-1:0] count;
		stripe_point_t  expected_points[$];
		int             errors;

		function new();
			threshold = THRESHOLD_RESET;
			row       = '0;
			column    = '0;
			peak      = '0;
			col_sum   = '0;
			count     = '0;
			errors    = 0;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		// one accepted pixel transaction
		function void note_pixel(bit [PIX_W-1:0] pix, bit last_in_row, bit last_in_frame);
			bit            row_done;
			stripe_point_t pt;
			if (column == 0 || pix > peak) begin
				peak    = pix;
				col_sum = SUM_W'(column);
				count   = CNT_W'(1);
			end else if (pix == peak) begin
				col_sum += SUM_W'(column);
				count   += CNT_W'(1);
			end
			row_done = last_in_row || last_in_frame || column == COL_W'(MAX_COLUMNS - 1);
			if (!row_done) begin
				column += COL_W'(1);
				return;
			end
			if (peak > threshold && count != 0) begin
				pt.row      = row;
				pt.centroid = COL_W'(col_sum / SUM_W'(count));
				pt.peak     = peak;
				pt.count    = count;
				expected_points = {expected_points, pt};
			end
			if (last_in_frame || row == ROW_W'(MAX_ROWS - 1))
				row = '0;
			else
				row += ROW_W'(1);
			column  = '0;
			peak    = '0;
			col_sum = '0;
			count   = '0;
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				// keep the log bounded when the block is badly off
				if (errors <= REPORT_LIMIT)
					$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		// one accepted result transaction
		function void check_point(stripe_point_t got);
			stripe_point_t want;
			if (expected_points.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: unexpected point, expected none, actual row %0d column %0d",
						$time, got.row, got.centroid);
				return;
			end
			want = expected_points.pop_front();
			compare_field("row_index", want.row, got.row);
			compare_field("centroid_column", want.centroid, got.centroid);
			compare_field("peak_level", want.peak, got.peak);
			compare_field("peak_pixels", want.count, got.count);
		endfunction
	endclass

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             push;
	logic             full;
	logic [PIX_W-1:0] pixel_value;
	logic             row_end;
	logic             frame_end;
	logic             cfg_we;
	logic [PIX_W-1:0] cfg_wdata;
	logic             empty;
	logic             pop;
	logic [ROW_W-1:0] row_index;
	logic [COL_W-1:0] centroid_column;
	logic [PIX_W-1:0] peak_level;
	logic [CNT_W-1:0] peak_pixels;

	bit                 calm = 1'b0;
	int                 results_seen = 0;
	int                 quiet_cycles = 0;
	centroid_scoreboard sb = new();

	laser_stripe_row_centroid i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.pixel_value     (pixel_value),
		.row_end         (row_end),
		.frame_end       (frame_end),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.empty           (empty),
		.pop             (pop),
		.row_index       (row_index),
		.centroid_column (centroid_column),
		.peak_level      (peak_level),
		.peak_pixels     (peak_pixels)
	);

	always #2 clk = ~clk;

	initial begin
		push        <= 1'b0;
		pixel_value <= '0;
		row_end     <= 1'b0;
		frame_end   <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		pop         <= 1'b0;
	end

	// monitor and watchdog: values read here are the ones seen at the edge
	always @(posedge clk) begin
		stripe_point_t got;
		if (push && !full)
			sb.note_pixel(pixel_value, row_end, frame_end);
		if (pop && !empty) begin
			got.row      = row_index;
			got.centroid = centroid_column;
			got.peak     = peak_level;
			got.count    = peak_pixels;
			sb.check_point(got);
			results_seen++;
		end
		if ((push && !full) || (pop && !empty) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		bit held_off;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && results_seen >= 30) begin
				held_off = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				pop <= calm || $urandom_range(99) >= 28;
				@(posedge clk);
			end
		end
	end

	task automatic send_pixel(input bit [PIX_W-1:0] pix, input bit last_in_row,
		input bit last_in_frame);
		while (!calm && $urandom_range(99) < 28) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		pixel_value <= pix;
		row_end     <= last_in_row;
		frame_end   <= last_in_frame;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		// let the monitor note the last accepted transaction first
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		// dim rows leave nothing to wait for, so give the back end time to go quiet
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input bit [PIX_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = value;
	endtask

	task automatic send_random_row(input int unsigned len, input bit ends_frame);
		row_shape_t     shape;
		int unsigned    spot;
		int unsigned    span;
		bit [PIX_W-1:0] level;
		bit [PIX_W-1:0] pix;
		bit             in_stripe;
		shape = row_shape_t'($urandom_range(3));
		spot  = $urandom_range(len - 1);
		span  = $urandom_range(1, 4);
		level = PIX_W'($urandom_range(255));
		for (int unsigned c = 0; c < len; c++) begin
			in_stripe = c >= spot && c < spot + span;
			unique case (shape)
				SHAPE_NOISE: pix = PIX_W'($urandom_range(255));
				SHAPE_STRIPE: pix = in_stripe ? level : PIX_W'($urandom_range(60));
				SHAPE_FLAT: pix = level;
				default: begin
					// plateau with holes, so equal peaks are split across the row
					pix = (in_stripe && $urandom_range(1)) ? level : level >> $urandom_range(1, 3);
				end
			endcase
			if (c == len - 1)
				send_pixel(pix, ends_frame ? 1'($urandom_range(1)) : 1'b1, ends_frame);
			else
				send_pixel(pix, 1'b0, 1'b0);
		end
	endtask

	initial begin
		bit [PIX_W-1:0] thr;
		int unsigned    budget;
		int unsigned    sent;
		int unsigned    len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at the reset threshold
		send_pixel(8'd255, 1'b1, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b1, 1'b0);
		send_pixel(8'd51, 1'b0, 1'b0);
		send_pixel(8'd50, 1'b0, 1'b0);
		send_pixel(8'd51, 1'b1, 1'b0);
		// peak equal to the threshold gives nothing
		send_pixel(8'd50, 1'b0, 1'b0);
		send_pixel(8'd50, 1'b1, 1'b0);
		send_pixel(8'd10, 1'b0, 1'b0);
		send_pixel(8'd200, 1'b0, 1'b0);
		send_pixel(8'd100, 1'b0, 1'b0);
		send_pixel(8'd200, 1'b0, 1'b0);
		send_pixel(8'd200, 1'b1, 1'b0);
		// frame end without row end still closes the row
		send_pixel(8'd60, 1'b0, 1'b0);
		send_pixel(8'd90, 1'b0, 1'b1);
		send_pixel(8'd255, 1'b1, 1'b0);
		send_pixel(8'd128, 1'b1, 1'b1);

		for (int ph = 0; ph < 5; ph++) begin
			unique case (ph)
				0: thr = 8'd0;
				1: thr = PIX_W'($urandom_range(30, 150));
				2: thr = 8'd255;
				3: thr = PIX_W'($urandom_range(255));
				default: thr = 8'd128;
			endcase
			budget = (ph == 1) ? 150 : ((ph == 2) ? 30 : 60);
			wait_drained();
			write_threshold(thr);
			sent = 0;
			while (sent < budget) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
				calm = ph == 1 && sent < 200;
				send_random_row(len, $urandom_range(14) == 0);
				sent += len;
			end
			calm = 1'b0;
		end

		// overlong row: a full-width plateau closes itself at the last column
		wait_drained();
		write_threshold(8'd100);
		for (int c = 0; c < MAX_COLUMNS; c++)
			send_pixel(8'd200, 1'b0, 1'b0);
		send_pixel(8'd7, 1'b1, 1'b0);

		// run the row index past its top without a frame end
		send_pixel(8'd0, 1'b1, 1'b1);
		for (int r = 0; r < MAX_ROWS + 2; r++)
			send_pixel((r == MAX_ROWS - 1 || r == MAX_ROWS) ? 8'd255 : PIX_W'($urandom_range(255)),
				1'b1, 1'b0);

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> laser_stripe_row_centroid.f
src/lsrc_pkg.sv
src/lsrc_front.sv
src/lsrc_queue.sv
src/lsrc_back.sv
src/laser_stripe_row_centroid.sv
src/lsrc_checker.sv
tb/sv/laser_stripe_row_centroid_test.sv
